[src/qpc_pkg.sv]
`default_nettype none

package qpc_pkg;

    // Configuration register indexes.
    localparam logic [7:0] REG_GAIN_BASE        = 8'd0;
    localparam logic [7:0] REG_GAIN_SPAN        = 8'd1;
    localparam logic [7:0] REG_REFERENCE_SPAN   = 8'd2;
    localparam logic [7:0] REG_REFERENCE_OFFSET = 8'd3;

    // Register reset values.
    localparam logic [7:0] GAIN_BASE_RST        = 8'd10;
    localparam logic [7:0] GAIN_SPAN_RST        = 8'd60;
    localparam logic [9:0] REFERENCE_SPAN_RST   = 10'd250;
    localparam logic [9:0] REFERENCE_OFFSET_RST = 10'd20;

    // Angle arithmetic. The bias is a multiple of a full turn that makes
    // every 16-bit signed position non-negative.
    localparam logic [16:0] DEGREES    = 17'd360;
    localparam logic [16:0] TURN_BIAS  = 17'd33120;
    localparam logic [9:0]  DUTY_MAX   = 10'd1023;

    // One input word.
    typedef struct packed {
        logic       mode;
        logic       enc_a;
        logic       enc_b;
        logic [9:0] ref_sample;
        logic [9:0] gain_sample;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic [9:0]         duty;
        logic               direction;
        logic signed [15:0] position;
        logic [8:0]         angle;
        logic [10:0]        target_angle;
        logic [8:0]         loop_gain;
    } t_out_word;

    // One configuration write.
    typedef struct packed {
        logic [7:0] index;
        logic [9:0] value;
    } t_cfg_word;

    // Operations of the shared arithmetic unit.
    typedef enum logic [1:0] {
        OP_MUL,
        OP_CSUB,
        OP_ADIF
    } t_alu_op;

    typedef struct packed {
        t_alu_op     op;
        logic [16:0] a;
        logic [16:0] b;
    } t_alu_cmd;

    typedef struct packed {
        logic [20:0] res;
        logic        ge;
    } t_alu_rsp;

    // Counter controls from the sequencer.
    typedef struct packed {
        logic enc_strobe;
        logic tick_strobe;
        logic enc_a;
        logic enc_b;
    } t_cnt_ctl;

    // Floor of x / 1023 for x up to 1023 * 1023, by the reciprocal series.
    function automatic logic [9:0] div1023(input logic [19:0] x);
        logic [20:0] sum;
        sum = {1'b0, x} + {11'd0, x[19:10]} + 21'd1;
        return sum[19:10];
    endfunction

endpackage

`default_nettype wire

[src/qpc_if.sv]
`default_nettype none

// Valid/ready channel carrying one word of type T_WORD.
interface qpc_chan_if #(
    parameter type T_WORD = logic
) ();
    logic  valid;
    logic  ready;
    T_WORD data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/qpc_alu.sv]
`default_nettype none

module qpc_alu
    import qpc_pkg::*;
(
    input  wire t_alu_cmd i_cmd,
    output t_alu_rsp      o_rsp
);

    logic [16:0] w_diff_ab;
    logic [16:0] w_diff_ba;
    logic        w_ge;

    // Both differences and the compare share one subtractor pair.
    assign w_ge      = (i_cmd.a >= i_cmd.b);
    assign w_diff_ab = i_cmd.a - i_cmd.b;
    assign w_diff_ba = i_cmd.b - i_cmd.a;

    always_comb begin
        o_rsp.ge = w_ge;
        unique case (i_cmd.op)
            OP_MUL:  o_rsp.res = 21'(i_cmd.a[10:0] * i_cmd.b[9:0]);
            OP_CSUB: o_rsp.res = {4'd0, (w_ge ? w_diff_ab : i_cmd.a)};
            OP_ADIF: o_rsp.res = {4'd0, (w_ge ? w_diff_ab : w_diff_ba)};
            default: o_rsp.res = '0;
        endcase
    end

endmodule

`default_nettype wire

[src/qpc_counter.sv]
`default_nettype none

module qpc_counter
    import qpc_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire t_cnt_ctl      i_ctl,
    output logic signed [15:0] o_position
);

    logic [1:0]         r_last_ab;
    logic signed [7:0]  r_quarter;
    logic signed [15:0] r_position;

    logic [1:0]         w_pair;
    logic signed [7:0]  w_bias;
    logic signed [7:0]  w_periods;
    logic signed [7:0]  w_rem;

    assign w_pair = {i_ctl.enc_b, i_ctl.enc_a};

    // Whole periods truncated toward zero; the remainder stays in the counter.
    assign w_bias    = r_quarter + (r_quarter[7] ? 8'sd3 : 8'sd0);
    assign w_periods = w_bias >>> 2;
    assign w_rem     = r_quarter - (w_periods <<< 2);

    // Quarter-step decoding and period transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_ab  <= 2'b00;
            r_quarter  <= '0;
            r_position <= '0;
        end else if (i_ctl.tick_strobe) begin
            r_quarter  <= w_rem;
            r_position <= r_position + {{8{w_periods[7]}}, w_periods};
        end else if (i_ctl.enc_strobe && (w_pair != r_last_ab)) begin
            if (i_ctl.enc_a == r_last_ab[1]) begin
                r_quarter <= r_quarter - 8'sd1;
            end else begin
                r_quarter <= r_quarter + 8'sd1;
            end
            r_last_ab <= w_pair;
        end
    end

    assign o_position = r_position;

    // After a tick only a partial period is left.
    a_quarter_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.tick_strobe |=> (r_quarter >= -8'sd3 && r_quarter <= 8'sd3))
        else $error("quarter remainder out of range after tick");

    // An encoder sample never moves the position.
    a_enc_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.enc_strobe && !i_ctl.tick_strobe) |=> $stable(r_position))
        else $error("position moved on an encoder sample");

endmodule

`default_nettype wire

[src/quadrature_position_p_controller.sv]
`default_nettype none

// Channel  Role    Word         Accepted when
// i_in     sink    t_in_word    i_in.valid && i_in.ready
// o_out    source  t_out_word   o_out.valid && o_out.ready
// i_cfg    sink    t_cfg_word   i_cfg.valid && i_cfg.ready (always ready)
//
// An encoder sample gives no word.
// A control tick reaches the output register through three multiply or
// scale steps, eight restoring steps of the modulo 360, then error and duty,
// all on one shared multiply/compare-subtract unit but the final gain scaling.
// A stalled output holds the sequencer in its last state until the word leaves.
// Reset is synchronous and active low; it restores the register defaults.

module quadrature_position_p_controller
    import qpc_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    qpc_chan_if.sink   i_in,
    qpc_chan_if.source o_out,
    qpc_chan_if.sink   i_cfg
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REF_MUL,
        S_GAIN_MUL,
        S_GAIN_FIN,
        S_MOD,
        S_ERR,
        S_DUTY_MUL,
        S_OUT
    } t_state;

    t_state             r_state;
    logic [2:0]         r_step;
    logic [9:0]         r_ref_sample;
    logic [9:0]         r_gain_sample;
    logic [20:0]        r_prod;
    logic [10:0]        r_ref;
    logic [8:0]         r_gain;
    logic [16:0]        r_rem;
    logic [10:0]        r_err;
    logic               r_dir;
    t_out_word          r_out;
    logic               r_out_valid;

    logic [7:0]         r_gain_base;
    logic [7:0]         r_gain_span;
    logic [9:0]         r_reference_span;
    logic [9:0]         r_reference_offset;

    t_alu_cmd           w_cmd;
    t_alu_rsp           w_rsp;
    t_cnt_ctl           w_cnt;
    logic signed [15:0] w_position;
    logic               w_in_acc;
    logic [9:0]         w_div;
    logic [9:0]         w_gain_sum;
    logic               w_out_free;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;

    // Counter strobes straight from the accepted word.
    assign w_cnt.enc_strobe  = w_in_acc && !i_in.data.mode;
    assign w_cnt.tick_strobe = w_in_acc && i_in.data.mode;
    assign w_cnt.enc_a       = i_in.data.enc_a;
    assign w_cnt.enc_b       = i_in.data.enc_b;

    qpc_counter u_counter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_cnt),
        .o_position (w_position)
    );

    qpc_alu u_alu (
        .i_cmd (w_cmd),
        .o_rsp (w_rsp)
    );

    // Scaling of the last registered product.
    assign w_div      = div1023(r_prod[19:0]);
    assign w_gain_sum = {2'b00, r_gain_base} + w_div;

    // Operand selection for the shared unit.
    always_comb begin
        w_cmd.op = OP_MUL;
        w_cmd.a  = '0;
        w_cmd.b  = '0;
        unique case (r_state)
            S_REF_MUL: begin
                w_cmd.a = {7'd0, r_ref_sample};
                w_cmd.b = {7'd0, r_reference_span};
            end
            S_GAIN_MUL: begin
                w_cmd.a = {7'd0, r_gain_sample};
                w_cmd.b = {9'd0, r_gain_span};
            end
            S_MOD: begin
                w_cmd.op = OP_CSUB;
                w_cmd.a  = r_rem;
                w_cmd.b  = DEGREES << r_step;
            end
            S_ERR: begin
                w_cmd.op = OP_ADIF;
                w_cmd.a  = {6'd0, r_ref};
                w_cmd.b  = {8'd0, r_rem[8:0]};
            end
            S_DUTY_MUL: begin
                w_cmd.a = {6'd0, r_err};
                w_cmd.b = {8'd0, r_gain};
            end
            default: begin
                w_cmd.op = OP_MUL;
            end
        endcase
    end

    // Sequencer, configuration registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state            <= S_IDLE;
            r_step             <= '0;
            r_out_valid        <= 1'b0;
            r_gain_base        <= GAIN_BASE_RST;
            r_gain_span        <= GAIN_SPAN_RST;
            r_reference_span   <= REFERENCE_SPAN_RST;
            r_reference_offset <= REFERENCE_OFFSET_RST;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.data.index)
                    REG_GAIN_BASE:        r_gain_base        <= i_cfg.data.value[7:0];
                    REG_GAIN_SPAN:        r_gain_span        <= i_cfg.data.value[7:0];
                    REG_REFERENCE_SPAN:   r_reference_span   <= i_cfg.data.value;
                    REG_REFERENCE_OFFSET: r_reference_offset <= i_cfg.data.value;
                    default: ;
                endcase
            end

            // The output state reloads the word itself when it leaves.
            if (r_out_valid && o_out.ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && i_in.data.mode) begin
                        r_ref_sample  <= i_in.data.ref_sample;
                        r_gain_sample <= i_in.data.gain_sample;
                        r_state       <= S_REF_MUL;
                    end
                end
                S_REF_MUL: begin
                    r_prod  <= w_rsp.res;
                    r_rem   <= {w_position[15], w_position} + TURN_BIAS;
                    r_state <= S_GAIN_MUL;
                end
                S_GAIN_MUL: begin
                    r_ref   <= {1'b0, r_reference_offset} + {1'b0, w_div};
                    r_prod  <= w_rsp.res;
                    r_state <= S_GAIN_FIN;
                end
                S_GAIN_FIN: begin
                    r_gain  <= w_gain_sum[8:0];
                    r_step  <= 3'd7;
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    r_rem  <= w_rsp.res[16:0];
                    r_step <= r_step - 3'd1;
                    if (r_step == 3'd0) begin
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_dir   <= !w_rsp.ge;
                    r_err   <= w_rsp.res[10:0];
                    r_state <= S_DUTY_MUL;
                end
                S_DUTY_MUL: begin
                    r_prod  <= w_rsp.res;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out.duty         <= (r_prod > {11'd0, DUTY_MAX}) ?
                                              DUTY_MAX : r_prod[9:0];
                        r_out.direction    <= r_dir;
                        r_out.position     <= w_position;
                        r_out.angle        <= r_rem[8:0];
                        r_out.target_angle <= r_ref;
                        r_out.loop_gain    <= r_gain;
                        r_out_valid        <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // The modulo steps leave an angle below a full turn.
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ERR) |-> (r_rem < DEGREES))
        else $error("angle remainder not reduced below 360");

    // Scaled gain and reference stay in their ranges.
    a_scale_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ERR) |-> (r_gain <= 9'd510 && r_ref <= 11'd2046))
        else $error("scaled gain or reference out of range");

    // A control tick keeps the input closed on the following cycle.
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in.data.mode) |=> !i_in.ready)
        else $error("input reopened right after a control tick");

    // A waiting word is never overwritten.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled output word changed");

endmodule

`default_nettype wire

[test/qpc_tb_pkg.sv]
`timescale 1ns / 1ps

package qpc_tb_pkg;

    // Kinds of input word.
    localparam logic MODE_ENCODER = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

endpackage

[test/qpc_tick_checker.sv]
`timescale 1ns / 1ps

module qpc_tick_checker
    import qpc_pkg::*, qpc_tb_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    input  wire       i_in_ready,
    input  t_in_word  i_in_data,
    input  wire       i_out_valid,
    input  wire       i_out_ready,
    input  t_out_word i_out_data,
    input  wire       i_cfg_valid,
    input  wire       i_cfg_ready,
    input  t_cfg_word i_cfg_data,
    output int        o_mismatches,
    output int        o_pending
);

    localparam int FULL_SCALE          = 1023;
    localparam int TURN                = 360;
    localparam int QUARTERS_PER_PERIOD = 4;
    localparam int DUTY_LIMIT          = 1023;

    // Our own copy of the settings and the counters.
    logic [7:0]         gain_base;
    logic [7:0]         gain_span;
    logic [9:0]         ref_span;
    logic [9:0]         ref_offset;
    logic [1:0]         prev_pair;
    logic signed [7:0]  quarters;
    logic signed [15:0] periods;

    t_out_word expected_ticks[$];
    int        field_errors;

    assign o_mismatches = field_errors;

    // An encoder word moves the quarter count only when the pair changes.
    function automatic void advance_quarters(input t_in_word w);
        logic [1:0] pair;
        pair = {w.enc_b, w.enc_a};
        if (pair != prev_pair) begin
            if (w.enc_a == prev_pair[1])
                quarters = quarters - 8'sd1;
            else
                quarters = quarters + 8'sd1;
            prev_pair = pair;
        end
    endfunction

    // A control tick folds whole periods into the position and drives the motor.
    function automatic t_out_word run_control_tick(input t_in_word w);
        int        q;
        int        whole;
        int        pos;
        int        ang;
        int        ref_deg;
        int        gain;
        int        err;
        int        prod;
        t_out_word r;
        q = quarters;
        whole = q / QUARTERS_PER_PERIOD;
        quarters = 8'(q - whole * QUARTERS_PER_PERIOD);
        periods = periods + 16'(whole);

        ref_deg = int'(ref_offset) + (int'(w.ref_sample) * int'(ref_span)) / FULL_SCALE;
        gain = int'(gain_base) + (int'(w.gain_sample) * int'(gain_span)) / FULL_SCALE;

        // Floored modulo: a negative position still lands in 0..359.
        pos = periods;
        ang = pos % TURN;
        if (ang < 0)
            ang = ang + TURN;

        if (ang <= ref_deg) begin
            r.direction = 1'b0;
            err = ref_deg - ang;
        end else begin
            r.direction = 1'b1;
            err = ang - ref_deg;
        end
        prod = gain * err;
        if (prod > DUTY_LIMIT)
            prod = DUTY_LIMIT;

        r.duty = 10'(prod);
        r.position = periods;
        r.angle = 9'(ang);
        r.target_angle = 11'(ref_deg);
        r.loop_gain = 9'(gain);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            field_errors++;
        end
    endfunction

    // Watch all three channels; results are checked before new ticks are queued.
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            gain_base  = GAIN_BASE_RST;
            gain_span  = GAIN_SPAN_RST;
            ref_span   = REFERENCE_SPAN_RST;
            ref_offset = REFERENCE_OFFSET_RST;
            prev_pair  = 2'b00;
            quarters   = 8'sd0;
            periods    = 16'sd0;
            expected_ticks.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_ticks.size() == 0) begin
                    $error("result word with no control tick waiting");
                    field_errors++;
                end else begin
                    want = expected_ticks.pop_front();
                    check_field("duty", want.duty, i_out_data.duty);
                    check_field("direction", want.direction, i_out_data.direction);
                    check_field("position", $signed(want.position),
                                $signed(i_out_data.position));
                    check_field("angle", want.angle, i_out_data.angle);
                    check_field("target_angle", want.target_angle,
                                i_out_data.target_angle);
                    check_field("loop_gain", want.loop_gain, i_out_data.loop_gain);
                end
            end

            // Writes to an unknown index leave every setting alone.
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_data.index)
                    REG_GAIN_BASE:        gain_base  = i_cfg_data.value[7:0];
                    REG_GAIN_SPAN:        gain_span  = i_cfg_data.value[7:0];
                    REG_REFERENCE_SPAN:   ref_span   = i_cfg_data.value;
                    REG_REFERENCE_OFFSET: ref_offset = i_cfg_data.value;
                    default: ;
                endcase
            end

            if (i_in_valid && i_in_ready) begin
                if (i_in_data.mode == MODE_TICK)
                    expected_ticks.push_back(run_control_tick(i_in_data));
                else
                    advance_quarters(i_in_data);
            end
        end
        o_pending <= expected_ticks.size();
    end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
    import qpc_pkg::*;
    import qpc_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 400;
    localparam int PHASES       = 6;
    localparam int DRAIN_CYCLES = 24;

    logic       clk;
    logic       rst_n;
    bit         steady;
    logic [1:0] enc_pair;
    int         mismatches;
    int         pending;
    int         cycles;

    qpc_chan_if #(.T_WORD(t_in_word))  in_ch ();
    qpc_chan_if #(.T_WORD(t_out_word)) out_ch ();
    qpc_chan_if #(.T_WORD(t_cfg_word)) cfg_ch ();

    quadrature_position_p_controller DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    qpc_tick_checker tick_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_data    (in_ch.data),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_data   (out_ch.data),
        .i_cfg_valid  (cfg_ch.valid),
        .i_cfg_ready  (cfg_ch.ready),
        .i_cfg_data   (cfg_ch.data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop if the block hangs.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // The result side stalls in random bursts until the last phase.
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (!steady && $urandom_range(0, 2) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    end

    // Ready is sampled on the falling edge, when it has settled.
    task automatic await_ready(input bit on_cfg);
        bit taken;
        do begin
            @(negedge clk);
            taken = on_cfg ? cfg_ch.ready : in_ch.ready;
            @(posedge clk);
        end while (!taken);
    endtask

    task automatic push_word(input t_in_word w);
        if (!steady && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        await_ready(1'b0);
        if (w.mode == MODE_ENCODER)
            enc_pair = {w.enc_b, w.enc_a};
    endtask

    // The sample fields ride along with random content; the block ignores them.
    function automatic t_in_word encoder_word(input bit a, input bit b);
        t_in_word w;
        w.mode = MODE_ENCODER;
        w.enc_a = a;
        w.enc_b = b;
        w.ref_sample = 10'($urandom);
        w.gain_sample = 10'($urandom);
        return w;
    endfunction

    function automatic t_in_word tick_word(input logic [9:0] ref_s, input logic [9:0] gain_s);
        t_in_word w;
        w.mode = MODE_TICK;
        w.enc_a = 1'($urandom);
        w.enc_b = 1'($urandom);
        w.ref_sample = ref_s;
        w.gain_sample = gain_s;
        return w;
    endfunction

    // One clean quadrature step: flipping A counts up when A and B agree.
    task automatic turn(input bit up);
        bit a;
        bit b;
        a = enc_pair[0];
        b = enc_pair[1];
        if ((a == b) == up)
            a = ~a;
        else
            b = ~b;
        push_word(encoder_word(a, b));
    endtask

    task automatic cfg_put(input logic [7:0] idx, input logic [9:0] val);
        t_cfg_word c;
        c.index = idx;
        c.value = val;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= c;
        await_ready(1'b1);
    endtask

    task automatic load_settings(input logic [9:0] base, input logic [9:0] span,
                                 input logic [9:0] rspan, input logic [9:0] roff,
                                 input bit stray);
        cfg_put(REG_GAIN_BASE, base);
        cfg_put(REG_GAIN_SPAN, span);
        cfg_put(REG_REFERENCE_SPAN, rspan);
        cfg_put(REG_REFERENCE_OFFSET, roff);
        if (stray)
            cfg_put(8'($urandom_range(4, 255)), 10'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    // Drop valid and wait out every pending tick plus the block's own latency.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Mostly clean step runs closed by a tick, with noise and lone ticks mixed in.
    task automatic random_stretch(input int quota);
        int done;
        int ticks;
        int len;
        bit up;
        t_in_word w;
        done = 0;
        ticks = 0;
        while (done < quota || ticks < 4) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    w = encoder_word(1'($urandom), 1'($urandom));
                    if ({w.enc_b, w.enc_a} != enc_pair)
                        done++;
                    push_word(w);
                end
                2: begin
                    push_word(tick_word(10'($urandom), 10'($urandom)));
                    ticks++;
                    done++;
                end
                default: begin
                    up = 1'($urandom);
                    // A rare long run can wrap the quarter count.
                    len = ($urandom_range(0, 15) == 0) ? $urandom_range(120, 160)
                                                       : $urandom_range(1, 6);
                    repeat (len) turn(up);
                    push_word(tick_word(10'($urandom), 10'($urandom)));
                    done += len + 1;
                    ticks++;
                end
            endcase
        end
    endtask

    initial begin
        steady = 1'b0;
        enc_pair = 2'b00;
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset settings.
        push_word(tick_word(10'd0, 10'd0));
        push_word(encoder_word(1'b0, 1'b0));
        repeat (5) turn(1'b1);
        push_word(tick_word(10'd1023, 10'd1023));
        repeat (9) turn(1'b0);
        push_word(tick_word(10'd512, 10'd0));
        push_word(encoder_word(~enc_pair[0], ~enc_pair[1]));
        push_word(tick_word(10'd1023, 10'd1023));

        // Random phases, each under its own settings; the last one runs without gaps.
        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            case (phase)
                0: load_settings(10'd0, 10'd0, 10'd0, 10'd0, 1'b0);
                1: load_settings(10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff, 1'b0);
                default: load_settings(10'($urandom), 10'($urandom), 10'($urandom),
                                       10'($urandom), phase == 2);
            endcase
            if (phase == PHASES - 1)
                steady = 1'b1;
            random_stretch(RANDOM_WORDS / PHASES);
        end
        settle();

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
